// ===== rtl/ofb_pkg.sv =====
`timescale 1ns / 1ps

package ofb_pkg;

    localparam int CHANNELS      = 4;
    localparam int SAMPLE_BITS   = 10;
    localparam int CH_BITS       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HDR_BYTES     = 4;
    localparam int FRAME_BYTES   = HDR_BYTES + 4 * CHANNELS;
    localparam int BYTE_IDX_BITS = $clog2(FRAME_BYTES);

    localparam logic [15:0] SPC_RESET = 16'd632;
    localparam logic [7:0]  HDR_A     = 8'hFF;
    localparam logic [7:0]  HDR_B     = 8'hFE;

    // weight, temperature, internal, supply, then the rest in order
    localparam logic [7:0][2:0] SEND_ORDER = {3'd7, 3'd6, 3'd5, 3'd4,
                                              3'd3, 3'd1, 3'd0, 3'd2};

    typedef enum logic {
        ST_ACC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accumulate;
        logic load_byte;
        logic clear_totals;
    } cmd_t;

    typedef struct packed {
        logic frame_done;
        logic last_byte;
        logic out_free;
    } sts_t;

    function automatic logic [CH_BITS-1:0] send_src(input logic [CH_BITS-1:0] slot);
        logic [3:0] pos;
        logic [3:0] src;
        pos = 4'(slot);
        if (pos < 4'd8)
        begin
            src = {1'b0, SEND_ORDER[pos[2:0]]};
        end
        else
        begin
            src = pos;
        end
        if (src >= 4'(CHANNELS))
        begin
            src = pos;
        end
        return CH_BITS'(src);
    endfunction

endpackage

// ===== rtl/ofb_ctrl.sv =====
`timescale 1ns / 1ps

module ofb_ctrl
    import ofb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  sts_t   sts,
    output cmd_t   cmd,
    output logic   in_stall,
    output state_t state
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACC:
            begin
                if (in_valid && sts.frame_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.last_byte)
                begin
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_ACC:
            begin
                in_stall       = 1'b0;
                cmd.accumulate = in_valid;
            end
            ST_EMIT:
            begin
                cmd.load_byte    = sts.out_free;
                // totals are cleared as the last frame word leaves them
                cmd.clear_totals = sts.out_free && sts.last_byte;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign state = state_reg;

endmodule

// ===== rtl/ofb_dp.sv =====
`timescale 1ns / 1ps

module ofb_dp
    import ofb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic                   cfg_write,
    input  logic [15:0]            cfg_data,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [7:0]             pin_state,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             frame_byte,
    output logic                   frame_end
);

    logic [31:0]              totals_reg [CHANNELS];
    logic [31:0]              totals_next [CHANNELS];
    logic [15:0]              spc_reg;
    logic [15:0]              cnt_reg;
    logic [15:0]              cnt_next;
    logic [15:0]              cnt_inc;
    logic [CH_BITS-1:0]       ch_reg;
    logic [CH_BITS-1:0]       ch_next;
    logic                     ch_last;
    logic                     chan_done;
    logic [BYTE_IDX_BITS-1:0] byte_idx_reg;
    logic [BYTE_IDX_BITS-1:0] byte_idx_next;
    logic [BYTE_IDX_BITS-1:0] body_idx;
    logic [CH_BITS-1:0]       slot;
    logic [31:0]              word;
    logic [7:0]               sel_byte;
    logic [7:0]               pins_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [7:0]               frame_byte_reg;
    logic                     frame_end_reg;
    logic [31:0]              sample_ext;

    assign sample_ext = 32'(sample);
    assign cnt_inc    = cnt_reg + 16'd1;
    assign chan_done  = (cnt_inc == spc_reg);
    assign ch_last    = (ch_reg == CH_BITS'(CHANNELS - 1));

    assign sts.frame_done = chan_done && ch_last;
    assign sts.last_byte  = (byte_idx_reg == BYTE_IDX_BITS'(FRAME_BYTES - 1));
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // one adder per channel lane, enabled by the channel pointer
    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            totals_next[i] = totals_reg[i];
            if (cmd.clear_totals)
            begin
                totals_next[i] = '0;
            end
            else if (cmd.accumulate && (ch_reg == CH_BITS'(i)))
            begin
                totals_next[i] = totals_reg[i] + sample_ext;
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        ch_next  = ch_reg;
        if (cmd.accumulate)
        begin
            if (chan_done)
            begin
                cnt_next = '0;
                ch_next  = ch_last ? '0 : ch_reg + CH_BITS'(1);
            end
            else
            begin
                cnt_next = cnt_inc;
            end
        end
    end

    assign body_idx = byte_idx_reg - BYTE_IDX_BITS'(HDR_BYTES);
    assign slot     = CH_BITS'(body_idx >> 2);
    assign word     = totals_reg[send_src(slot)];

    always_comb
    begin
        priority if (byte_idx_reg < BYTE_IDX_BITS'(2))
        begin
            sel_byte = HDR_A;
        end
        else if (byte_idx_reg == BYTE_IDX_BITS'(2))
        begin
            sel_byte = HDR_B;
        end
        else if (byte_idx_reg == BYTE_IDX_BITS'(3))
        begin
            sel_byte = pins_reg;
        end
        else
        begin
            unique case (body_idx[1:0])
                2'd0:    sel_byte = word[7:0];
                2'd1:    sel_byte = word[15:8];
                2'd2:    sel_byte = word[23:16];
                default: sel_byte = word[31:24];
            endcase
        end
    end

    always_comb
    begin
        byte_idx_next  = byte_idx_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_byte)
        begin
            out_valid_next = 1'b1;
            byte_idx_next  = sts.last_byte ? '0 : byte_idx_reg + BYTE_IDX_BITS'(1);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                totals_reg[i] <= '0;
            end
            spc_reg       <= SPC_RESET;
            cnt_reg       <= '0;
            ch_reg        <= '0;
            byte_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                totals_reg[i] <= totals_next[i];
            end
            if (cfg_write)
            begin
                spc_reg <= cfg_data;
            end
            cnt_reg       <= cnt_next;
            ch_reg        <= ch_next;
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accumulate)
        begin
            pins_reg <= pin_state;
        end
        if (cmd.load_byte)
        begin
            frame_byte_reg <= sel_byte;
            frame_end_reg  <= sts.last_byte;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign frame_end  = frame_end_reg;

endmodule

// ===== rtl/oversampled_adc_frame_builder_unit.sv =====
`timescale 1ns / 1ps

// Oversampling converter accumulator. Samples arrive in channel order
// temperature, internal, weight, supply; each channel sums samples_per_channel
// samples (0 means 65536) into a 32-bit wrapping total. While accumulating, a
// sample is taken whenever in_valid is high. The sample that closes the supply
// channel starts a 20-word frame (FF FF FE, pin snapshot, weight/temperature/
// internal/supply totals LSB first); the frame leaves one word per cycle while
// out_stall is low, from a single output register, and in_stall stays high
// until the last word is loaded. Totals clear as the last word is loaded.
// Write samples_per_channel only while no frame is in flight.
module oversampled_adc_frame_builder_unit
    import ofb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            samples_per_channel,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [7:0]             pin_state,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             frame_byte,
    output logic                   frame_end
);

    cmd_t   cmd;
    sts_t   sts;
    state_t state;

    assign cfg_ready = 1'b1;

    ofb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall),
        .state    (state)
    );

    ofb_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (samples_per_channel),
        .sample     (sample),
        .pin_state  (pin_state),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_end  (frame_end)
    );

`ifndef SYNTHESIS
    a_load_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_byte |-> (state == ST_EMIT))
        else $error("frame word loaded outside emit");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && sts.frame_done) |=> (state == ST_EMIT && in_stall))
        else $error("frame not started after closing sample");

    a_frame_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_byte && sts.last_byte) |=> (state == ST_ACC && out_valid && frame_end))
        else $error("frame end not flagged on last word");

    a_no_accum_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_EMIT) |-> !cmd.accumulate)
        else $error("sample summed during frame output");
`endif

endmodule
